@@ src/mca_pkg.sv @@
// Shared types and constants for the mean and covariance accumulator.
`default_nettype none
package mca_pkg;

  localparam int DIM_MAX    = 4;
  localparam int IDX_W      = 2;
  localparam int DIM_W      = 3;
  localparam int CNT_W      = 17;
  localparam int MAX_POINTS = 65535;

  localparam logic KIND_MEAN = 1'b0;
  localparam logic KIND_COV  = 1'b1;

  // One element as classified by the front end.
  typedef struct packed {
    logic signed [15:0] sample;
    logic [IDX_W-1:0]   idx;
    logic               complete;
    logic               last;
  } fe_item_t;

  // One result word.
  typedef struct packed {
    logic               kind;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [47:0] value;
    logic               error;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

@@ src/mca_fifo.sv @@
// Small synchronous queue built from registers.
`default_nettype none
module mca_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ src/mca_front.sv @@
// Front end: holds the dim register and tags each element with its place in a point.
`default_nettype none
module mca_front import mca_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [DIM_W-1:0]   cfg_dim,
  input  wire logic               in_push,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               in_last_point,
  input  wire logic               q_full,
  output logic                    q_push,
  output fe_item_t                q_item,
  output logic [DIM_W-1:0]        dim_eff
);
  logic [DIM_W-1:0] dim_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             complete;

  always_comb begin
    if (dim_r == '0) begin
      dim_eff = DIM_W'(1);
    end else if (dim_r > DIM_W'(DIM_MAX)) begin
      dim_eff = DIM_W'(DIM_MAX);
    end else begin
      dim_eff = dim_r;
    end
  end

  assign q_push   = in_push && !q_full;
  assign complete = ({1'b0, idx_r} + DIM_W'(1)) >= dim_eff;

  always_comb begin
    q_item.sample   = in_sample;
    q_item.idx      = idx_r;
    q_item.complete = complete;
    q_item.last     = in_last_point;
    idx_nxt         = idx_r;
    if (q_push) begin
      idx_nxt = (complete || in_last_point) ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_W'(DIM_MAX);
      idx_r <= '0;
    end else begin
      if (cfg_we) begin
        dim_r <= cfg_dim;
      end
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/mca_div.sv @@
// Divider of a signed dividend by an unsigned divisor, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module mca_div import mca_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [CNT_W-1:0]   divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);
  logic             busy_r;
  logic [6:0]       cnt_r;
  logic             neg_r;
  logic [CNT_W-1:0] rem_r;
  logic [63:0]      quo_r;
  logic [CNT_W:0]   shifted, trial;
  logic             fit;
  logic             done_r;

  assign shifted  = {rem_r, quo_r[63]};
  assign trial    = shifted - {1'b0, divisor};
  assign fit      = shifted >= {1'b0, divisor};
  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      neg_r <= dividend[63];
      rem_r <= '0;
      quo_r <= dividend[63] ? 64'(-dividend) : 64'(dividend);
    end else if (busy_r) begin
      rem_r <= fit ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_r <= {quo_r[62:0], fit};
    end
  end

endmodule
`default_nettype wire

@@ src/mca_back.sv @@
// Back end: accumulates points and computes the mean and covariance words.
`default_nettype none
module mca_back import mca_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [DIM_W-1:0]   dim_eff,
  input  wire fe_item_t           q_item,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire logic               r_full,
  output logic                    r_push,
  output res_t                    r_item,
  output logic                    div_start,
  output logic signed [63:0]      div_dividend,
  output logic [CNT_W-1:0]        div_divisor,
  input  wire logic               div_done,
  input  wire logic signed [63:0] div_quotient
);
  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_MEAN_START, S_MEAN_WAIT, S_MEAN_PUSH,
    S_COV_START, S_COV_WAIT, S_COV_FIN, S_COV_PUSH
  } state_t;

  state_t state_r;
  logic signed [15:0] rb_r   [DIM_MAX];
  logic signed [32:0] sv_r   [DIM_MAX];
  logic signed [47:0] sp_r   [DIM_MAX*DIM_MAX];
  logic signed [31:0] mean_r [DIM_MAX];
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic               last_r;
  logic [IDX_W-1:0]   i_r, j_r, d_m1;
  logic signed [63:0] pm_r;
  logic signed [48:0] e_r;
  logic signed [47:0] val_r;

  logic signed [31:0] prod;
  logic [2*IDX_W-1:0] pidx;
  logic signed [63:0] p_biased;
  logic signed [49:0] v_wide;
  logic signed [47:0] v_sat;
  logic               run_last;

  assign d_m1     = IDX_W'(dim_eff - DIM_W'(1));
  assign pidx     = {i_r, j_r};
  assign prod     = rb_r[i_r] * rb_r[j_r];
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign run_last = (i_r == d_m1) && (j_r == d_m1);

  assign div_start   = ((state_r == S_MEAN_START) || (state_r == S_COV_START)) &&
                       (cnt_r != '0);
  assign div_divisor = cnt_r;
  assign div_dividend = (state_r == S_MEAN_START) ?
                        {{15{sv_r[i_r][32]}}, sv_r[i_r], 16'b0} :
                        {sp_r[pidx], 16'b0};

  // Truncate the squared-mean term toward zero, then saturate the difference.
  assign p_biased = pm_r + (pm_r[63] ? 64'sd65535 : 64'sd0);
  assign v_wide   = {e_r[48], e_r} - {{2{p_biased[63]}}, p_biased[63:16]};
  always_comb begin
    if (v_wide[49:47] == 3'b000 || v_wide[49:47] == 3'b111) begin
      v_sat = v_wide[47:0];
    end else if (v_wide[49]) begin
      v_sat = {1'b1, 47'b0};
    end else begin
      v_sat = {1'b0, {47{1'b1}}};
    end
  end

  assign r_push = ((state_r == S_MEAN_PUSH) || (state_r == S_COV_PUSH)) && !r_full;
  always_comb begin
    r_item.kind  = (state_r == S_COV_PUSH) ? KIND_COV : KIND_MEAN;
    r_item.row   = i_r;
    r_item.col   = (state_r == S_COV_PUSH) ? j_r : '0;
    r_item.value = val_r;
    r_item.error = ovf_r || (cnt_r == '0);
    r_item.last  = (state_r == S_COV_PUSH) && run_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      for (int k = 0; k < DIM_MAX; k++) begin
        rb_r[k] <= '0;
        sv_r[k] <= '0;
      end
      for (int k = 0; k < DIM_MAX*DIM_MAX; k++) begin
        sp_r[k] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            rb_r[q_item.idx] <= q_item.sample;
            last_r <= q_item.last;
            i_r    <= '0;
            j_r    <= '0;
            if (q_item.complete && cnt_r < CNT_W'(MAX_POINTS)) begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_MAC;
            end else begin
              if (q_item.complete) begin
                ovf_r <= 1'b1;
              end
              state_r <= q_item.last ? S_MEAN_START : S_IDLE;
            end
          end
        end
        S_MAC: begin
          sp_r[pidx] <= sp_r[pidx] + 48'(prod);
          if (j_r == '0) begin
            sv_r[i_r] <= sv_r[i_r] + 33'(rb_r[i_r]);
          end
          if (j_r == d_m1) begin
            j_r <= '0;
            if (i_r == d_m1) begin
              i_r     <= '0;
              state_r <= last_r ? S_MEAN_START : S_IDLE;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_MEAN_START: begin
          if (cnt_r == '0) begin
            mean_r[i_r] <= '0;
            val_r       <= '0;
            state_r     <= S_MEAN_PUSH;
          end else begin
            state_r <= S_MEAN_WAIT;
          end
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean_r[i_r] <= div_quotient[31:0];
            val_r       <= 48'(div_quotient);
            state_r     <= S_MEAN_PUSH;
          end
        end
        S_MEAN_PUSH: begin
          if (!r_full) begin
            if (i_r == d_m1) begin
              i_r     <= '0;
              j_r     <= '0;
              state_r <= S_COV_START;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_MEAN_START;
            end
          end
        end
        S_COV_START: begin
          pm_r <= mean_r[i_r] * mean_r[j_r];
          if (cnt_r == '0) begin
            val_r   <= '0;
            state_r <= S_COV_PUSH;
          end else begin
            state_r <= S_COV_WAIT;
          end
        end
        S_COV_WAIT: begin
          if (div_done) begin
            e_r     <= div_quotient[48:0];
            state_r <= S_COV_FIN;
          end
        end
        S_COV_FIN: begin
          val_r   <= v_sat;
          state_r <= S_COV_PUSH;
        end
        S_COV_PUSH: begin
          if (!r_full) begin
            state_r <= S_COV_START;
            if (j_r == d_m1) begin
              j_r <= '0;
              if (i_r == d_m1) begin
                // Run is over: clear the accumulators for the next set.
                i_r     <= '0;
                cnt_r   <= '0;
                ovf_r   <= 1'b0;
                state_r <= S_IDLE;
                for (int k = 0; k < DIM_MAX; k++) begin
                  rb_r[k] <= '0;
                  sv_r[k] <= '0;
                end
                for (int k = 0; k < DIM_MAX*DIM_MAX; k++) begin
                  sp_r[k] <= '0;
                end
              end else begin
                i_r <= i_r + 1'b1;
              end
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CNT_W'(MAX_POINTS)))
    else $error("overflow flag set below the point limit");
  a_no_div_empty: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (cnt_r != '0))
    else $error("divider started with a zero point count");
  a_last_is_cov: assert property (@(posedge clk) disable iff (!rst_n)
    (r_push && r_item.last) |=> (state_r == S_IDLE))
    else $error("final result not followed by return to idle");
  a_wait_has_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_MEAN_WAIT || state_r == S_COV_WAIT))
    else $error("divider started outside a wait sequence");
`endif

endmodule
`default_nettype wire

@@ src/mean_covariance_accumulator.sv @@
// Top level of the streaming mean and covariance accumulator.
//
//   channel  ports                                       handshake
//   input    in_sample, in_last_point                    in_push / in_full
//   result   out_kind/row/col/value/error/last           out_pop / out_empty
//   config   cfg_dim                                     cfg_we
//
// An element passes the front end without a register; a point-completing
// element then steps through every (row, column) pair in the back end's single
// 16x16 multiply-add. At the end of a set each result word waits on the
// one-bit-per-cycle divider, unless no point was counted.
// Reset is synchronous and active low; dim returns to 4 and all sums clear.
// A queue sits on each side of the back end, so a stall at the output reaches
// the input only once the result queue and then the element queue have filled.
`default_nettype none
module mean_covariance_accumulator import mca_pkg::*; #(
  parameter int QUEUE_DEPTH  = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [DIM_W-1:0]   cfg_dim,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               in_last_point,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic                    out_kind,
  output logic [1:0]              out_row,
  output logic [1:0]              out_col,
  output logic signed [47:0]      out_value,
  output logic                    out_error,
  output logic                    out_last
);
  // Front end: classifies each element against the configured dimension.
  logic             q_push, q_full, q_pop, q_empty;
  fe_item_t         q_wr, q_rd;
  logic [DIM_W-1:0] dim_eff;

  mca_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_dim, .in_push, .in_sample, .in_last_point,
    .q_full, .q_push, .q_item(q_wr), .dim_eff
  );

  assign in_full = q_full;

  // Element queue between the front and back ends.
  mca_fifo #(.W($bits(fe_item_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(q_push), .wr_data(q_wr), .full(q_full),
    .pop(q_pop), .rd_data(q_rd), .empty(q_empty)
  );

  // Back end with its shared divider.
  logic               div_start, div_done;
  logic signed [63:0] div_dividend, div_quotient;
  logic [CNT_W-1:0]   div_divisor;
  logic               r_push, r_full;
  res_t               r_wr, r_rd;

  mca_back u_back (
    .clk, .rst_n, .dim_eff, .q_item(q_rd), .q_empty, .q_pop,
    .r_full, .r_push, .r_item(r_wr),
    .div_start, .div_dividend, .div_divisor, .div_done, .div_quotient
  );

  mca_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quotient)
  );

  // Result queue: the oldest word is presented while out_empty is low.
  mca_fifo #(.W($bits(res_t)), .DEPTH(RESULT_DEPTH)) u_results (
    .clk, .rst_n, .push(r_push), .wr_data(r_wr), .full(r_full),
    .pop(out_pop), .rd_data(r_rd), .empty(out_empty)
  );

  assign out_kind  = r_rd.kind;
  assign out_row   = r_rd.row;
  assign out_col   = r_rd.col;
  assign out_value = r_rd.value;
  assign out_error = r_rd.error;
  assign out_last  = r_rd.last;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the mean and covariance accumulator.
`default_nettype none
module tb_top;
  import mca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Idle patterns. The sender and the receiver take turns being the slow side,
  // and the final pattern runs both sides at full rate.
  typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

  localparam int  ITEM_TARGET = 340;
  localparam int  DRAIN_WAIT  = 300;
  localparam bit [DIM_W-1:0] DIM_RESET = 3'd4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [DIM_W-1:0]   cfg_dim = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic signed [15:0] in_sample = '0;
  logic               in_last_point = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_kind;
  logic [1:0]         out_row;
  logic [1:0]         out_col;
  logic signed [47:0] out_value;
  logic               out_error;
  logic               out_last;

  mean_covariance_accumulator u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_dim(cfg_dim),
    .in_push(in_push), .in_full(in_full), .in_sample(in_sample),
    .in_last_point(in_last_point), .out_empty(out_empty), .out_pop(out_pop),
    .out_kind(out_kind), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .out_error(out_error), .out_last(out_last)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generous ceiling on the time that a full run with every stall takes.
  initial begin
    #30ms;
    $display("Timeout with %0d result words still expected", result_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the register and of the running sums.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] dim_reg;
  longint           point_buf [DIM_MAX];
  longint           elem_sum  [DIM_MAX];
  longint           prod_sum  [DIM_MAX*DIM_MAX];
  int unsigned      npoints;
  int unsigned      elem_pos;
  bit               count_ovf;

  res_t result_q [$];   // result words the block still owes us

  idle_mode_t idle_mode = IDLE_SEND_LIGHT;
  int  hold_cycles = 0;
  int  items_sent = 0;
  int  sets_closed = 0;
  int  words_checked = 0;
  int  mismatches = 0;

  function automatic int unsigned active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > DIM_MAX) return DIM_MAX;
    return dim_reg;
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < DIM_MAX; i++) begin
      point_buf[i] = 0;
      elem_sum[i] = 0;
    end
    for (int i = 0; i < DIM_MAX*DIM_MAX; i++) prod_sum[i] = 0;
    npoints = 0;
    elem_pos = 0;
    count_ovf = 1'b0;
  endfunction

  // Folds one accepted element into the sums and, when it closes the set,
  // queues the mean vector followed by the row-major covariance matrix.
  function automatic void absorb_element(logic signed [15:0] smp, logic set_end);
    int unsigned d;
    longint      n;
    longint      mu [DIM_MAX];
    longint      ex, pr, v;
    bit          err;
    int          total, k;
    res_t        r;
    d = active_dim();
    if (elem_pos >= DIM_MAX) elem_pos = DIM_MAX - 1;
    point_buf[elem_pos] = longint'(smp);
    // A point closes as soon as the position reaches the current dim, even if
    // dim was changed while the point was half received.
    if (elem_pos + 1 >= d) begin
      elem_pos = 0;
      if (npoints >= MAX_POINTS) begin
        count_ovf = 1'b1;
      end else begin
        npoints++;
        for (int i = 0; i < d; i++) begin
          elem_sum[i] += point_buf[i];
          for (int j = 0; j < d; j++)
            prod_sum[i*DIM_MAX+j] += point_buf[i] * point_buf[j];
        end
      end
    end else begin
      elem_pos++;
    end
    if (!set_end) return;
    // A partial point at the end of the set is simply dropped.
    n = longint'(npoints);
    err = count_ovf || (n == 0);
    total = d + d*d;
    k = 0;
    for (int i = 0; i < d; i++) begin
      mu[i] = (n == 0) ? 0 : (elem_sum[i] * 65536) / n;
      r = '{kind: KIND_MEAN, row: i[1:0], col: 2'd0, value: mu[i][47:0],
            error: err, last: (k + 1 == total)};
      result_q.push_back(r);
      k++;
    end
    for (int i = 0; i < d; i++) begin
      for (int j = 0; j < d; j++) begin
        v = 0;
        if (n != 0) begin
          ex = (prod_sum[i*DIM_MAX+j] * 65536) / n;
          pr = (mu[i] * mu[j]) / 65536;
          v = ex - pr;
          if (v > 64'sh7FFF_FFFF_FFFF) v = 64'sh7FFF_FFFF_FFFF;
          if (v < -64'sh8000_0000_0000) v = -64'sh8000_0000_0000;
        end
        r = '{kind: KIND_COV, row: i[1:0], col: j[1:0], value: v[47:0],
              error: err, last: (k + 1 == total)};
        result_q.push_back(r);
        k++;
      end
    end
    sets_closed++;
    clear_sums();
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pops at random or, in IDLE_NONE, always; honors a hold-off, and
  // checks every word that leaves the block against the oldest predicted word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      words_checked++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: kind %0d row %0d col %0d value %0d",
                   out_kind, out_row, out_col, out_value);
      end else begin
        want = result_q.pop_front();
        if (out_kind !== want.kind || out_row !== want.row || out_col !== want.col ||
            out_value !== want.value || out_error !== want.error ||
            out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Result mismatch: expected kind %0d row %0d col %0d value %0d ",
                      "err %0d last %0d, got %0d %0d %0d %0d %0d %0d"},
                     want.kind, want.row, want.col, want.value, want.error, want.last,
                     out_kind, out_row, out_col, out_value, out_error, out_last);
        end
      end
    end
    // Decide whether to pop at the next edge.
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_pop <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_SEND_LIGHT: out_pop <= ($urandom_range(99) >= 55);
        IDLE_SEND_HEAVY: out_pop <= ($urandom_range(99) >= 38);
        default:         out_pop <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offers one element and holds it until the block takes it. The push stays
  // high into the next call unless the sender decides to idle.
  task automatic push_element(input logic signed [15:0] smp, input logic set_end);
    int pct;
    in_sample <= smp;
    in_last_point <= set_end;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    absorb_element(smp, set_end);
    items_sent++;
    pct = (idle_mode == IDLE_SEND_LIGHT) ? 38 : (idle_mode == IDLE_SEND_HEAVY) ? 55 : 0;
    if ($urandom_range(99) < pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Waits until every predicted word has come out, then gives the back end
  // time to finish any element that produces no result.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_dim(input logic [DIM_W-1:0] d);
    drain();
    cfg_dim <= d;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_reg = d;
  endtask

  // Sends npts complete points of random data, the last one flagged as the end.
  task automatic send_set(input int npts, input int lo, input int hi);
    int d;
    d = active_dim();
    for (int p = 0; p < npts; p++)
      for (int e = 0; e < d; e++)
        push_element(16'($urandom_range(hi - lo) + lo), (p == npts-1) && (e == d-1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Full-scale samples at the reset dim of four, then at dim one.
  task automatic test_extremes();
    push_element(16'sh7FFF, 1'b0);
    push_element(-16'sh8000, 1'b0);
    push_element(16'sh7FFF, 1'b0);
    push_element(-16'sh8000, 1'b0);
    push_element(-16'sh8000, 1'b0);
    push_element(16'sh7FFF, 1'b0);
    push_element(16'sh0000, 1'b0);
    push_element(-16'sh0001, 1'b1);
    set_dim(3'd1);
    push_element(-16'sh8000, 1'b0);
    push_element(-16'sh8000, 1'b1);
  endtask

  // A set with no complete point, and a set whose final point is cut short.
  task automatic test_empty_and_partial();
    set_dim(3'd3);
    push_element(16'sd1234, 1'b1);
    push_element(16'sd5, 1'b0);
    push_element(-16'sd7, 1'b0);
    push_element(16'sd9, 1'b0);
    push_element(16'sd100, 1'b0);
    push_element(16'sd200, 1'b1);
  endtask

  // dim values outside 1..4 are clamped; a dim change mid-point closes the
  // point early.
  task automatic test_dim_corners();
    set_dim(3'd0);
    push_element(16'sd300, 1'b0);
    push_element(-16'sd20, 1'b1);
    set_dim(3'd7);
    send_set(2, -500, 500);
    set_dim(3'd4);
    push_element(16'sd11, 1'b0);
    push_element(16'sd22, 1'b0);
    push_element(16'sd33, 1'b0);
    set_dim(3'd2);
    push_element(16'sd44, 1'b0);
    push_element(16'sd55, 1'b0);
    push_element(16'sd66, 1'b1);
  endtask

  // Random sets with random dim, point count and the odd ragged ending.
  task automatic test_random_sets();
    int npts, d, cut;
    idle_mode = IDLE_SEND_LIGHT;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET/3)   idle_mode = IDLE_SEND_HEAVY;
      if (items_sent > 2*ITEM_TARGET/3) idle_mode = IDLE_NONE;
      if ($urandom_range(2) == 0) set_dim(3'($urandom_range(7)));
      d = active_dim();
      npts = $urandom_range(6);
      case ($urandom_range(9))
        0: begin
          // Ragged ending: a few stray elements, the last one marking the end.
          cut = $urandom_range(d - 1, 1);
          send_set(npts, -32768, 32767);
          if (d > 1) begin
            for (int e = 0; e < cut; e++)
              push_element(16'($urandom), e == cut - 1);
          end else begin
            push_element(16'($urandom), 1'b1);
          end
        end
        1: send_set(npts + 1, -4, 4);
        default: send_set(npts + 1, -32768, 32767);
      endcase
    end
    idle_mode = IDLE_NONE;
  endtask

  // The receiver stops for a long stretch while two sets are offered, so the
  // result queue and then the input queue fill and the input stalls.
  task automatic test_backpressure();
    set_dim(3'd4);
    idle_mode = IDLE_NONE;
    hold_cycles = 4000;
    send_set(3, -32768, 32767);
    send_set(8, -32768, 32767);
  endtask

  initial begin
    dim_reg = DIM_RESET;
    clear_sums();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_empty_and_partial();
    test_dim_corners();
    test_random_sets();
    test_backpressure();

    drain();
    $display("Covered %0d elements in %0d sets, all dims incl. clamped ones,", items_sent,
             sets_closed);
    $display("empty and ragged sets and a long output stall; checked %0d result words.",
             words_checked);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, result_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
